// File: rtl/core/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int TOTAL_W     = 16;
  localparam int WIN_CFG_W   = 6;
  localparam int CFG_IDX_W   = 1;

  localparam logic [TOTAL_W-1:0]   TOTAL_RESET  = 16'd1;
  localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = 6'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_ACK     = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  typedef struct packed {
    logic all_acked;
    logic bad_ack;
  } gbn_flags_t;

endpackage

// File: rtl/core/gbn_queue.sv
`timescale 1ns / 1ps

module gbn_queue import gbn_pkg::*; #(
  parameter int W = 36
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         valid
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/core/gbn_front.sv
`timescale 1ns / 1ps

module gbn_front import gbn_pkg::*; #(
  parameter int WINDOW_MAX = 32,
  parameter int SEQ_BITS   = 16,
  localparam int PTR_W     = ((SEQ_BITS > TOTAL_W) ? SEQ_BITS : TOTAL_W) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_data,
  input  logic                 take,
  input  logic [1:0]           req_type,
  input  logic [SEQ_BITS-1:0]  ack_num,
  output logic [PTR_W-1:0]     job_start,
  output logic [PTR_W-1:0]     job_stop,
  output gbn_flags_t           job_flags
);

  localparam int WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = PTR_W + 1;

  logic [TOTAL_W-1:0]   total_r;
  logic [WIN_CFG_W-1:0] window_r;
  logic [PTR_W-1:0]     base_r, base_nxt;
  logic [PTR_W-1:0]     next_r, next_nxt;
  logic [TOTAL_W-1:0]   high_r, high_nxt;

  logic [WIN_W-1:0]     win;
  logic [PTR_W-1:0]     ack_ext;
  logic [PTR_W-1:0]     next_ev;
  logic                 bad;
  logic [SUM_W-1:0]     win_end;
  logic [SUM_W-1:0]     cap;
  logic [SUM_W-1:0]     limit_w;
  logic [PTR_W-1:0]     limit;
  logic                 send;

  always_comb begin
    if (window_r == '0) begin
      win = WIN_W'(1);
    end else if ({1'b0, window_r} > 7'(WINDOW_MAX)) begin
      win = WIN_W'(WINDOW_MAX);
    end else begin
      win = WIN_W'(window_r);
    end
  end

  assign ack_ext = PTR_W'(ack_num);

  always_comb begin
    base_nxt = base_r;
    next_ev  = next_r;
    high_nxt = high_r;
    bad      = 1'b0;
    case (req_type)
      REQ_START: begin
        base_nxt = PTR_W'(1);
        next_ev  = PTR_W'(1);
        high_nxt = '0;
      end
      REQ_ACK: begin
        if (ack_ext >= next_r) begin
          bad = 1'b1;
        end else if (ack_ext >= base_r) begin
          base_nxt = ack_ext + PTR_W'(1);
          high_nxt = ack_ext[TOTAL_W-1:0];
        end
      end
      REQ_TIMEOUT: begin
        next_ev = base_r;
      end
      default: begin
      end
    endcase
  end

  // stop at the window end or one past the last packet, whichever comes first
  assign win_end  = SUM_W'(base_nxt) + SUM_W'(win);
  assign cap      = SUM_W'(total_r) + SUM_W'(1);
  assign limit_w  = (win_end < cap) ? win_end : cap;
  assign limit    = limit_w[PTR_W-1:0];
  assign send     = (next_ev < limit);
  assign next_nxt = send ? limit : next_ev;

  assign job_start           = next_ev;
  assign job_stop            = next_nxt;
  assign job_flags.all_acked = (high_nxt >= total_r);
  assign job_flags.bad_ack   = bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= TOTAL_RESET;
      window_r <= WINDOW_RESET;
      base_r   <= PTR_W'(1);
      next_r   <= PTR_W'(1);
      high_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL:  total_r  <= cfg_data;
          CFG_WINDOW: window_r <= cfg_data[WIN_CFG_W-1:0];
          default: begin
          end
        endcase
      end
      if (take) begin
        base_r <= base_nxt;
        next_r <= next_nxt;
        high_r <= high_nxt;
      end
    end
  end

endmodule

// File: rtl/core/gbn_back.sv
`timescale 1ns / 1ps

module gbn_back import gbn_pkg::*; #(
  parameter int SEQ_BITS = 16,
  localparam int PTR_W   = ((SEQ_BITS > TOTAL_W) ? SEQ_BITS : TOTAL_W) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  logic [PTR_W-1:0]    job_start,
  input  logic [PTR_W-1:0]    job_stop,
  input  gbn_flags_t          job_flags,
  output logic                job_take,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [SEQ_BITS-1:0] out_seq_num,
  output logic                out_send_valid,
  output logic                out_last,
  output logic                out_all_acked,
  output logic                out_bad_ack
);

  logic               busy_r;
  logic [PTR_W-1:0]   cur_r;
  logic [PTR_W-1:0]   stop_r;
  gbn_flags_t         flags_r;
  logic [PTR_W-1:0]   cur_inc;
  logic               pop_beat;
  logic               load;

  assign cur_inc        = cur_r + PTR_W'(1);
  assign out_empty      = !busy_r;
  assign out_send_valid = (cur_r != stop_r);
  assign out_last       = !out_send_valid || (cur_inc == stop_r);
  assign out_seq_num    = out_send_valid ? cur_r[SEQ_BITS-1:0] : '0;
  assign out_all_acked  = flags_r.all_acked;
  assign out_bad_ack    = flags_r.bad_ack;

  assign pop_beat = out_pop && busy_r;
  assign load     = !busy_r || (pop_beat && out_last);
  assign job_take = load && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur_r   <= job_start;
      stop_r  <= job_stop;
      flags_r <= job_flags;
    end else if (pop_beat) begin
      cur_r <= cur_inc;
    end
  end

  a_cur_below_stop: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_send_valid |-> cur_r < stop_r)
    else $error("send pointer passed its stop");

  a_advance_one: assert property (@(posedge clk) disable iff (!rst_n)
    pop_beat && !out_last |=> busy_r && cur_r == $past(cur_inc))
    else $error("send pointer did not advance by one");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_send_valid |-> out_last && out_seq_num == '0)
    else $error("status beat not marked last");

endmodule

// File: rtl/core/go_back_n_sender_unit.sv
`timescale 1ns / 1ps
// channel | ports                                   | beat taken when
// input   | in_push, in_full, in_req_type, in_ack_num | in_push & !in_full
// result  | out_pop, out_empty, out_seq_num, out_send_valid,
//         | out_last, out_all_acked, out_bad_ack      | out_pop & !out_empty
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// Each taken event yields 1 to WINDOW_MAX result beats, one per cycle while
// out_pop is high, paced by the send counter of the back end.
// A two-entry job queue holds events whose beats are not yet started.
// Reset: base and next-to-send are 1, nothing acknowledged, total 1, window 4.
// in_full rises while the job queue is full; out_pop stalls the back end first.

module go_back_n_sender_unit import gbn_pkg::*; #(
  parameter int WINDOW_MAX = 32,
  parameter int SEQ_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_req_type,
  input  logic [SEQ_BITS-1:0]  in_ack_num,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [SEQ_BITS-1:0]  out_seq_num,
  output logic                 out_send_valid,
  output logic                 out_last,
  output logic                 out_all_acked,
  output logic                 out_bad_ack,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_data
);

  localparam int PTR_W = ((SEQ_BITS > TOTAL_W) ? SEQ_BITS : TOTAL_W) + 1;
  localparam int JOB_W = $bits(gbn_flags_t) + 2 * PTR_W;

  logic             accept;
  logic [PTR_W-1:0] f_start, f_stop;
  gbn_flags_t       f_flags;
  logic [PTR_W-1:0] b_start, b_stop;
  gbn_flags_t       b_flags;
  logic             q_full, q_valid, q_rd;
  logic [JOB_W-1:0] q_rd_data;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  gbn_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .SEQ_BITS   (SEQ_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (accept),
    .req_type  (in_req_type),
    .ack_num   (in_ack_num),
    .job_start (f_start),
    .job_stop  (f_stop),
    .job_flags (f_flags)
  );

  gbn_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data ({f_flags, f_start, f_stop}),
    .rd_en   (q_rd),
    .rd_data (q_rd_data),
    .full    (q_full),
    .valid   (q_valid)
  );

  assign {b_flags, b_start, b_stop} = q_rd_data;

  gbn_back #(
    .SEQ_BITS (SEQ_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_valid      (q_valid),
    .job_start      (b_start),
    .job_stop       (b_stop),
    .job_flags      (b_flags),
    .job_take       (q_rd),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_seq_num    (out_seq_num),
    .out_send_valid (out_send_valid),
    .out_last       (out_last),
    .out_all_acked  (out_all_acked),
    .out_bad_ack    (out_bad_ack)
  );

endmodule
